@@ sv/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the serial frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned WIN_LEN     = 7;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned LEN_W       = 17;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] HANDSHAKE_TYPE = 8'h01;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RX_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USER_ID_BYTE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN = 2'd3;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // One classified transaction passed from the parser to the result stage
  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [7:0]  sum;
    logic [7:0]  ftype;
    logic [15:0] fid;
    logic [15:0] flen;
  } entry_t;

endpackage

@@ sv/serial_frame_receiver_top.sv @@
// ----------------------------------------------------------------------------
// serial_frame_receiver_top
// Byte-serial frame parser with header search, length check and checksum.
//
//   channel   direction  handshake                   payload
//   input     in         push / full                 rx_byte_i
//   result    out        empty / pop                 result_kind_o .. handshake_request_o
//   config    in         cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// One byte is accepted per cycle while full is low; the parser updates its window
// and frame state in the accepting cycle, so throughput is one byte per clock.
// The queue is written at the edge that accepts the byte, and the result passes
// from the queue through the output register to the outputs. The four-entry queue plus
// output register absorb result stalls; full rises only when the queue is full.
// Reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module serial_frame_receiver_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      rx_byte_i,
  output logic                            empty,
  input  logic                            pop,
  output logic                            result_kind_o,
  output logic [7:0]                      data_byte_o,
  output logic                            frame_ok_o,
  output logic [7:0]                      frame_type_o,
  output logic [15:0]                     frame_id_o,
  output logic [15:0]                     payload_length_o,
  output logic                            handshake_request_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  sfr_pkg::entry_t front_entry;
  sfr_pkg::entry_t q_entry;
  logic            front_push;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  logic            byte_take;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign byte_take   = push && !q_full;

  sfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .byte_valid_i (byte_take),
    .byte_i       (rx_byte_i),
    .entry_push_o (front_push),
    .entry_o      (front_entry)
  );

  sfr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_push),
    .push_data_i (front_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_entry)
  );

  sfr_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_valid_i           (q_valid),
    .q_data_i            (q_entry),
    .q_pop_o             (q_pop),
    .empty               (empty),
    .pop                 (pop),
    .result_kind_o       (result_kind_o),
    .data_byte_o         (data_byte_o),
    .frame_ok_o          (frame_ok_o),
    .frame_type_o        (frame_type_o),
    .frame_id_o          (frame_id_o),
    .payload_length_o    (payload_length_o),
    .handshake_request_o (handshake_request_o)
  );

endmodule

@@ sv/sfr_front.sv @@
// ----------------------------------------------------------------------------
// sfr_front
// Byte parser: header window search, frame tracking and classification.
// ----------------------------------------------------------------------------
module sfr_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            byte_valid_i,
  input  logic [7:0]                      byte_i,
  output logic                            entry_push_o,
  output sfr_pkg::entry_t                 entry_o
);

  // Configuration registers
  logic                        rx_enable_q;
  logic [7:0]                  header_byte_q;
  logic [7:0]                  user_id_byte_q;
  logic [sfr_pkg::LEN_W-1:0]   max_frame_len_q;

  // Parser state
  logic [7:0]                  win_q [sfr_pkg::WIN_LEN];
  logic [7:0]                  win_d [sfr_pkg::WIN_LEN];
  logic [2:0]                  fill_q, fill_d;
  logic                        in_frame_q, in_frame_d;
  logic [sfr_pkg::LEN_W-1:0]   seen_q, seen_d;
  logic [sfr_pkg::LEN_W-1:0]   expected_q, expected_d;
  logic [7:0]                  sum_q, sum_d;

  logic [7:0]                  win_n [sfr_pkg::WIN_LEN];
  logic [2:0]                  wr_idx;
  logic [2:0]                  fill_n;
  logic [15:0]                 rep_len;
  logic [sfr_pkg::LEN_W-1:0]   total;
  logic [sfr_pkg::LEN_W-1:0]   seen_inc;
  logic [7:0]                  win_sum;
  logic                        hdr_ok;
  logic                        take;

  assign take = byte_valid_i && rx_enable_q;

  // Place the new byte into the window
  always_comb begin
    wr_idx = (fill_q >= 3'(sfr_pkg::WIN_LEN)) ? 3'(sfr_pkg::WIN_LEN - 1) : fill_q;
    fill_n = wr_idx + 3'd1;
    for (int i = 0; i < sfr_pkg::WIN_LEN; i++) begin
      win_n[i] = (wr_idx == 3'(i)) ? byte_i : win_q[i];
    end
  end

  // Check the full window
  always_comb begin
    rep_len = {win_n[4], win_n[3]};
    total   = sfr_pkg::LEN_W'(rep_len) + sfr_pkg::LEN_W'(8);
    hdr_ok  = (win_n[0] == header_byte_q) && (win_n[1] == user_id_byte_q) &&
              (total <= max_frame_len_q);
    win_sum = 8'h00;
    for (int i = 0; i < sfr_pkg::WIN_LEN; i++) begin
      win_sum = win_sum + win_n[i];
    end
    seen_inc = seen_q + sfr_pkg::LEN_W'(1);
  end

  // Advance the parser state and classify the byte
  always_comb begin
    win_d        = win_q;
    fill_d       = fill_q;
    in_frame_d   = in_frame_q;
    seen_d       = seen_q;
    expected_d   = expected_q;
    sum_d        = sum_q;
    entry_push_o = 1'b0;
    entry_o.kind  = sfr_pkg::KIND_PAYLOAD;
    entry_o.data  = byte_i;
    entry_o.sum   = sum_q;
    entry_o.ftype = win_q[2];
    entry_o.fid   = {win_q[6], win_q[5]};
    entry_o.flen  = {win_q[4], win_q[3]};
    if (take) begin
      if (!in_frame_q) begin
        win_d  = win_n;
        fill_d = fill_n;
        if (fill_n == 3'(sfr_pkg::WIN_LEN)) begin
          if (!hdr_ok) begin
            // drop the oldest byte
            for (int i = 0; i < sfr_pkg::WIN_LEN - 1; i++) begin
              win_d[i] = win_n[i+1];
            end
            win_d[sfr_pkg::WIN_LEN-1] = 8'h00;
            fill_d = 3'(sfr_pkg::WIN_LEN - 1);
          end else begin
            in_frame_d = 1'b1;
            seen_d     = sfr_pkg::LEN_W'(sfr_pkg::WIN_LEN);
            expected_d = total;
            sum_d      = win_sum;
          end
        end
      end else if (seen_inc < expected_q) begin
        entry_push_o = 1'b1;
        sum_d        = sum_q + byte_i;
        seen_d       = seen_inc;
      end else begin
        entry_push_o = 1'b1;
        entry_o.kind = sfr_pkg::KIND_VERDICT;
        in_frame_d   = 1'b0;
        fill_d       = 3'd0;
        seen_d       = '0;
        expected_d   = '0;
        sum_d        = 8'h00;
      end
    end
  end

  // Hold configuration and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_enable_q     <= 1'b1;
      header_byte_q   <= 8'd165;
      user_id_byte_q  <= 8'd1;
      max_frame_len_q <= sfr_pkg::LEN_W'(4096);
      fill_q          <= 3'd0;
      in_frame_q      <= 1'b0;
      seen_q          <= '0;
      expected_q      <= '0;
      sum_q           <= 8'h00;
    end else begin
      fill_q     <= fill_d;
      in_frame_q <= in_frame_d;
      seen_q     <= seen_d;
      expected_q <= expected_d;
      sum_q      <= sum_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          sfr_pkg::REG_RX_ENABLE:     rx_enable_q     <= cfg_data_i[0];
          sfr_pkg::REG_HEADER_BYTE:   header_byte_q   <= cfg_data_i[7:0];
          sfr_pkg::REG_USER_ID_BYTE:  user_id_byte_q  <= cfg_data_i[7:0];
          sfr_pkg::REG_MAX_FRAME_LEN: max_frame_len_q <= cfg_data_i[sfr_pkg::LEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Window bytes are payload; fill count decides what is valid
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

@@ sv/sfr_queue.sv @@
// ----------------------------------------------------------------------------
// sfr_queue
// Short queue of classified transactions between parser and result stage.
// ----------------------------------------------------------------------------
module sfr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sfr_pkg::entry_t  push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output sfr_pkg::entry_t  pop_data_o
);

  sfr_pkg::entry_t              mem_q [sfr_pkg::QUEUE_DEPTH];
  logic [sfr_pkg::QPTR_W-1:0]   wptr_q, rptr_q;
  logic [sfr_pkg::QCNT_W-1:0]   count_q;
  logic                         do_push, do_pop;

  assign full_o     = (count_q == sfr_pkg::QCNT_W'(sfr_pkg::QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + sfr_pkg::QPTR_W'(1);
      if (do_pop)  rptr_q <= rptr_q + sfr_pkg::QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + sfr_pkg::QCNT_W'(1);
        2'b01:   count_q <= count_q - sfr_pkg::QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // Store the pushed transaction
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_data_i;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sfr_pkg::QCNT_W'(sfr_pkg::QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + sfr_pkg::QCNT_W'(1)))
    else $error("queue occupancy did not follow push");
`endif

endmodule

@@ sv/sfr_back.sv @@
// ----------------------------------------------------------------------------
// sfr_back
// Result stage: checksum verdict, field formatting and output register.
// ----------------------------------------------------------------------------
module sfr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  sfr_pkg::entry_t  q_data_i,
  output logic             q_pop_o,
  output logic             empty,
  input  logic             pop,
  output logic             result_kind_o,
  output logic [7:0]       data_byte_o,
  output logic             frame_ok_o,
  output logic [7:0]       frame_type_o,
  output logic [15:0]      frame_id_o,
  output logic [15:0]      payload_length_o,
  output logic             handshake_request_o
);

  logic valid_q;
  logic load;
  logic ok;
  logic [7:0] want;

  assign empty   = !valid_q;
  assign load    = q_valid_i && (!valid_q || pop);
  assign q_pop_o = load;
  assign want    = 8'h00 - q_data_i.sum;
  assign ok      = (q_data_i.kind == sfr_pkg::KIND_VERDICT) && (q_data_i.data == want);

  // Hold the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (pop) begin
      valid_q <= 1'b0;
    end
  end

  // Format the result fields
  always_ff @(posedge clk_i) begin
    if (load) begin
      result_kind_o       <= q_data_i.kind;
      data_byte_o         <= (q_data_i.kind == sfr_pkg::KIND_VERDICT) ? 8'h00 : q_data_i.data;
      frame_ok_o          <= ok;
      frame_type_o        <= q_data_i.ftype;
      frame_id_o          <= q_data_i.fid;
      payload_length_o    <= q_data_i.flen;
      handshake_request_o <= ok && (q_data_i.ftype == sfr_pkg::HANDSHAKE_TYPE);
    end
  end

`ifndef SYNTHESIS
  a_verdict_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o == sfr_pkg::KIND_VERDICT) |-> (data_byte_o == 8'h00))
    else $error("verdict carries a data byte");
  a_handshake_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && handshake_request_o) |-> (frame_ok_o &&
      result_kind_o == sfr_pkg::KIND_VERDICT))
    else $error("handshake flagged on a bad frame");
`endif

endmodule

@@ test/tb_serial_frame_receiver_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_frame_receiver_top
// Drives framed byte streams through the serial frame receiver and checks
// every payload and verdict transaction against a behavioral parser that
// tracks the header window, frame length and running checksum.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic        kind;
  logic [7:0]  data;
  logic        ok;
  logic [7:0]  ftype;
  logic [15:0] fid;
  logic [15:0] flen;
  logic        hs;
} frame_result_t;

// Parser mirror: holds register copies, window state and the results still owed
class rx_frame_tracker;
  bit          en;
  bit [7:0]    hdr;
  bit [7:0]    uid;
  bit [16:0]   max_len;
  bit [7:0]    win [sfr_pkg::WIN_LEN];
  int unsigned fill;
  bit          in_frame;
  int unsigned seen;
  int unsigned total;
  bit [7:0]    sum;
  frame_result_t pending_results [$];
  int unsigned mismatches;

  function new();
    en       = 1'b1;
    hdr      = 8'd165;
    uid      = 8'd1;
    max_len  = 17'd4096;
    foreach (win[i]) win[i] = 8'h00;
    fill     = 0;
    in_frame = 1'b0;
    seen     = 0;
    total    = 0;
    sum      = 8'h00;
    mismatches = 0;
  endfunction

  function void write_reg(bit [sfr_pkg::CFG_IDX_W-1:0] idx, bit [16:0] value);
    case (idx)
      sfr_pkg::REG_RX_ENABLE:     en = value[0];
      sfr_pkg::REG_HEADER_BYTE:   hdr = value[7:0];
      sfr_pkg::REG_USER_ID_BYTE:  uid = value[7:0];
      sfr_pkg::REG_MAX_FRAME_LEN: max_len = value;
      default: ;
    endcase
  endfunction

  // Advance the parser by one accepted byte and queue any result it owes
  function void take_byte(bit [7:0] b);
    int unsigned tot;
    int unsigned i;
    bit [7:0] s;
    bit [7:0] want;
    frame_result_t r;
    if (!en) return;
    if (!in_frame) begin
      if (fill >= sfr_pkg::WIN_LEN) fill = sfr_pkg::WIN_LEN - 1;
      win[fill] = b;
      fill++;
      if (fill < sfr_pkg::WIN_LEN) return;
      tot = 8 + {win[4], win[3]};
      if (win[0] != hdr || win[1] != uid || tot > max_len) begin
        // drop the oldest byte and keep searching
        for (i = 0; i + 1 < sfr_pkg::WIN_LEN; i++) win[i] = win[i + 1];
        win[sfr_pkg::WIN_LEN - 1] = 8'h00;
        fill = sfr_pkg::WIN_LEN - 1;
        return;
      end
      s = 8'h00;
      for (i = 0; i < sfr_pkg::WIN_LEN; i++) s = s + win[i];
      sum      = s;
      in_frame = 1'b1;
      seen     = sfr_pkg::WIN_LEN;
      total    = tot;
      return;
    end
    r.ftype = win[2];
    r.fid   = {win[6], win[5]};
    r.flen  = {win[4], win[3]};
    if (seen + 1 < total) begin
      sum    = sum + b;
      seen   = seen + 1;
      r.kind = sfr_pkg::KIND_PAYLOAD;
      r.data = b;
      r.ok   = 1'b0;
      r.hs   = 1'b0;
    end else begin
      want   = 8'h00 - sum;
      r.kind = sfr_pkg::KIND_VERDICT;
      r.data = 8'h00;
      r.ok   = (b == want);
      r.hs   = r.ok && (win[2] == sfr_pkg::HANDSHAKE_TYPE);
      in_frame = 1'b0;
      fill     = 0;
      seen     = 0;
      total    = 0;
      sum      = 8'h00;
    end
    pending_results = {pending_results, r};
  endfunction

  function void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare one popped transaction with the oldest owed result
  function void match_result(frame_result_t got);
    frame_result_t want;
    if (pending_results.size() == 0) begin
      $error("result_kind: expected none actual %0h", got.kind);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    check_field("result_kind", want.kind, got.kind);
    check_field("data_byte", want.data, got.data);
    check_field("frame_ok", want.ok, got.ok);
    check_field("frame_type", want.ftype, got.ftype);
    check_field("frame_id", want.fid, got.fid);
    check_field("payload_length", want.flen, got.flen);
    check_field("handshake_request", want.hs, got.hs);
  endfunction
endclass

module tb_serial_frame_receiver_top;

  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned RANDOM_ITEMS  = 1200;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS   = 150;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           push = 1'b0;
  logic                           full;
  logic [7:0]                     rx_byte = 8'h00;
  logic                           empty;
  logic                           pop = 1'b0;
  logic                           result_kind;
  logic [7:0]                     data_byte;
  logic                           frame_ok;
  logic [7:0]                     frame_type;
  logic [15:0]                    frame_id;
  logic [15:0]                    payload_length;
  logic                           handshake_request;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  rx_frame_tracker tracker;
  bit              tx_idle;
  bit              rx_idle;
  int unsigned     cycle_count = 0;
  int unsigned     open_items = 0;
  bit [7:0]        frame_bytes [$];

  serial_frame_receiver_top dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .push                (push),
    .full                (full),
    .rx_byte_i           (rx_byte),
    .empty               (empty),
    .pop                 (pop),
    .result_kind_o       (result_kind),
    .data_byte_o         (data_byte),
    .frame_ok_o          (frame_ok),
    .frame_type_o        (frame_type),
    .frame_id_o          (frame_id),
    .payload_length_o    (payload_length),
    .handshake_request_o (handshake_request),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[serial_frame_receiver_top] ERROR");
      $finish;
    end
  end

  // Send one byte transaction, with an optional random gap in front
  task automatic send_byte(input bit [7:0] b);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    if (tracker.en) open_items++;
    tracker.take_byte(b);
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Stop sending and hold until every owed result has been popped
  task automatic quiesce();
    push <= 1'b0;
    do @(posedge clk); while (tracker.pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input bit [sfr_pkg::CFG_IDX_W-1:0] idx, input bit [16:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_all(input bit en, input bit [7:0] h, input bit [7:0] u,
                         input bit [16:0] max_len);
    quiesce();
    write_cfg(sfr_pkg::REG_RX_ENABLE, {16'd0, en});
    write_cfg(sfr_pkg::REG_HEADER_BYTE, {9'd0, h});
    write_cfg(sfr_pkg::REG_USER_ID_BYTE, {9'd0, u});
    write_cfg(sfr_pkg::REG_MAX_FRAME_LEN, max_len);
  endtask

  // Add one byte to the end of the frame being built
  task automatic append_byte(input bit [7:0] b);
    frame_bytes = {frame_bytes, b};
  endtask

  task automatic make_header(input bit [7:0] h, input bit [7:0] u, input bit [7:0] t,
                             input bit [15:0] len, input bit [15:0] fid);
    frame_bytes.delete();
    append_byte(h);
    append_byte(u);
    append_byte(t);
    append_byte(len[7:0]);
    append_byte(len[15:8]);
    append_byte(fid[7:0]);
    append_byte(fid[15:8]);
  endtask

  // Build a whole frame with random payload; optionally spoil the checksum
  task automatic make_frame(input bit [7:0] h, input bit [7:0] u, input bit [7:0] t,
                            input bit [15:0] len, input bit [15:0] fid, input bit bad);
    bit [7:0] s;
    bit [7:0] cks;
    make_header(h, u, t, len, fid);
    for (int unsigned i = 0; i < len; i++) append_byte(8'($urandom_range(0, 255)));
    s = 8'h00;
    foreach (frame_bytes[i]) s = s + frame_bytes[i];
    cks = 8'h00 - s;
    if (bad) cks = cks ^ 8'($urandom_range(1, 255));
    append_byte(cks);
  endtask

  task automatic send_range(input int unsigned lo, input int unsigned hi);
    for (int unsigned i = lo; i <= hi; i++) send_byte(frame_bytes[i]);
  endtask

  task automatic send_frame(input bit [7:0] h, input bit [7:0] u, input bit [7:0] t,
                            input bit [15:0] len, input bit [15:0] fid, input bit bad);
    make_frame(h, u, t, len, fid, bad);
    send_range(0, frame_bytes.size() - 1);
  endtask

  // Mostly short payloads, fitted to the current length limit most of the time
  function automatic bit [15:0] pick_len();
    int unsigned sel;
    int unsigned len;
    sel = $urandom_range(0, 9);
    if (sel < 3) len = $urandom_range(0, 2);
    else if (sel < 8) len = $urandom_range(3, 24);
    else len = $urandom_range(25, 200);
    if (8 + len > tracker.max_len && tracker.max_len >= 8 && $urandom_range(0, 3) != 0)
      len = tracker.max_len - 8;
    return 16'(len);
  endfunction

  function automatic bit [7:0] pick_type();
    return ($urandom_range(0, 3) == 0) ? sfr_pkg::HANDSHAKE_TYPE : 8'($urandom_range(0, 255));
  endfunction

  // One random stretch of stimulus: frames, noise, truncated or broken frames
  task automatic send_chunk();
    int unsigned sel;
    int unsigned k;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      send_frame(tracker.hdr, tracker.uid, pick_type(), pick_len(),
                 16'($urandom_range(0, 65535)), $urandom_range(0, 4) == 0);
    end else if (sel < 72) begin
      send_noise($urandom_range(1, 8));
    end else if (sel < 84) begin
      make_frame(tracker.hdr, tracker.uid, pick_type(), pick_len(),
                 16'($urandom_range(0, 65535)), 1'b0);
      k = $urandom_range(1, frame_bytes.size() - 1);
      send_range(0, k - 1);
    end else if (sel < 92) begin
      if ($urandom_range(0, 1) == 0)
        make_frame(tracker.hdr ^ 8'($urandom_range(1, 255)), tracker.uid, pick_type(),
                   pick_len(), 16'($urandom_range(0, 65535)), 1'b0);
      else
        make_frame(tracker.hdr, tracker.uid ^ 8'($urandom_range(1, 255)), pick_type(),
                   pick_len(), 16'($urandom_range(0, 65535)), 1'b0);
      send_range(0, frame_bytes.size() - 1);
    end else begin
      // one byte over the length limit: header only, then noise
      if (tracker.max_len >= 8 && tracker.max_len - 7 <= 65535) begin
        make_header(tracker.hdr, tracker.uid, pick_type(), 16'(tracker.max_len - 7),
                    16'($urandom_range(0, 65535)));
        send_range(0, 6);
      end
      send_noise($urandom_range(1, 4));
    end
  endtask

  // Result side: pop with random stalls and check each transaction
  initial begin : result_sink
    frame_result_t got;
    int unsigned gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = rx_idle ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got.kind  = result_kind;
      got.data  = data_byte;
      got.ok    = frame_ok;
      got.ftype = frame_type;
      got.fid   = frame_id;
      got.flen  = payload_length;
      got.hs    = handshake_request;
      tracker.match_result(got);
    end
  end

  initial begin : stimulus
    int unsigned sel;
    int unsigned phase_end;
    bit [16:0]   max_len;
    tracker = new();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: handshake frame with empty payload, then a bad checksum
    send_frame(8'd165, 8'd1, sfr_pkg::HANDSHAKE_TYPE, 16'd0, 16'h0000, 1'b0);
    send_frame(8'd165, 8'd1, sfr_pkg::HANDSHAKE_TYPE, 16'd1, 16'h1234, 1'b1);
    // Stray header byte in front: the window must slip and resync
    send_byte(8'hA5);
    send_frame(8'd165, 8'd1, 8'hFF, 16'd2, 16'hFFFF, 1'b0);

    // Close the port in the middle of a frame and shrink the limit, then resume
    make_frame(8'd165, 8'd1, 8'h00, 16'd4, 16'h8000, 1'b0);
    send_range(0, 8);
    quiesce();
    write_cfg(sfr_pkg::REG_RX_ENABLE, 17'd0);
    send_noise(3);
    quiesce();
    write_cfg(sfr_pkg::REG_MAX_FRAME_LEN, 17'd8);
    write_cfg(sfr_pkg::REG_RX_ENABLE, 17'd1);
    send_range(9, frame_bytes.size() - 1);

    // Length limit edges: frames that fit a limit exactly, a limit below the minimum, and one byte over a limit
    send_frame(8'd165, 8'd1, 8'h02, 16'd0, 16'h0001, 1'b0);
    quiesce();
    write_cfg(sfr_pkg::REG_MAX_FRAME_LEN, 17'd7);
    send_frame(8'd165, 8'd1, 8'h02, 16'd0, 16'h0002, 1'b0);
    quiesce();
    write_cfg(sfr_pkg::REG_MAX_FRAME_LEN, 17'd12);
    send_frame(8'd165, 8'd1, sfr_pkg::HANDSHAKE_TYPE, 16'd4, 16'h0003, 1'b0);
    send_frame(8'd165, 8'd1, sfr_pkg::HANDSHAKE_TYPE, 16'd5, 16'h0004, 1'b0);

    // Extreme identity bytes and the largest limit that a 16-bit length can need
    set_all(1'b1, 8'h00, 8'hFF, 17'd65543);
    send_frame(8'h00, 8'hFF, sfr_pkg::HANDSHAKE_TYPE, 16'd3, 16'h0000, 1'b0);
    set_all(1'b1, 8'hFF, 8'h00, 17'd4096);
    send_frame(8'hFF, 8'h00, 8'h7F, 16'd1, 16'hFFFF, 1'b0);

    // Random phases, each with its own settings and idling mode
    open_items = 0;
    while (open_items < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 5);
      case (sel)
        0: max_len = 17'd8;
        1: max_len = 17'($urandom_range(9, 40));
        2: max_len = 17'd4096;
        3: max_len = 17'd65543;
        4: max_len = 17'($urandom_range(8, 65543));
        default: max_len = 17'($urandom_range(200, 1000));
      endcase
      set_all(1'b1,
              ($urandom_range(0, 2) == 0) ? 8'd165 : 8'($urandom_range(0, 255)),
              ($urandom_range(0, 2) == 0) ? 8'd1 : 8'($urandom_range(0, 255)),
              max_len);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      // Occasionally close the port for a while
      if ($urandom_range(0, 5) == 0) begin
        write_cfg(sfr_pkg::REG_RX_ENABLE, 17'd0);
        send_noise(16);
        quiesce();
        write_cfg(sfr_pkg::REG_RX_ENABLE, 17'd1);
      end
      phase_end = open_items + PHASE_ITEMS;
      while (open_items < phase_end) send_chunk();
    end

    // One long frame at full rate on both sides
    set_all(1'b1, 8'd165, 8'd1, 17'd65543);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_frame(8'd165, 8'd1, sfr_pkg::HANDSHAKE_TYPE, 16'd96, 16'h5AA5, 1'b0);

    quiesce();
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("[serial_frame_receiver_top] OK");
    end else begin
      $display("[serial_frame_receiver_top] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/sfr_pkg.sv
sv/sfr_front.sv
sv/sfr_queue.sv
sv/sfr_back.sv
sv/serial_frame_receiver_top.sv
test/tb_serial_frame_receiver_top.sv
